// ===== sv/seismic_sample_to_double_macros.svh =====
// Assertion helpers for the sample converter.
`ifndef SEISMIC_SAMPLE_TO_DOUBLE_MACROS_SVH
`define SEISMIC_SAMPLE_TO_DOUBLE_MACROS_SVH
// Check an implication on every clock edge outside reset.
`define SSD_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Check an implication on every clock edge, reset included.
`define SSD_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ===== sv/ssd_pkg.sv =====
// ----------------------------------------------------------------------------
// ssd_pkg
// Shared types, format codes and constants for the sample converter.
// ----------------------------------------------------------------------------
package ssd_pkg;

    typedef logic [3:0]  fmt_code_t;
    typedef logic [31:0] sample_t;
    typedef logic [63:0] dbl_t;

    localparam fmt_code_t FMT_NONE   = 4'd0;
    localparam fmt_code_t FMT_IBM    = 4'd1;
    localparam fmt_code_t FMT_INT32  = 4'd2;
    localparam fmt_code_t FMT_INT16  = 4'd3;
    localparam fmt_code_t FMT_GAIN   = 4'd4;
    localparam fmt_code_t FMT_IEEE32 = 4'd5;
    localparam fmt_code_t FMT_INT8   = 4'd8;

    localparam dbl_t DBL_MINUS_ONE = 64'hBFF0_0000_0000_0000;

    // Position of the highest set bit of a 32-bit value (0 when zero).
    function automatic logic [4:0] top_bit(input logic [31:0] v);
        logic [4:0] p;
        p = 5'd0;
        for (int i = 0; i < 32; i++) begin
            if (v[i]) begin
                p = 5'(i);
            end
        end
        return p;
    endfunction

endpackage

// ===== sv/seismic_sample_to_double.sv =====
// ----------------------------------------------------------------------------
// seismic_sample_to_double
// Converts one big-endian seismic sample word to IEEE double bits.
// ----------------------------------------------------------------------------
// channel  dir  handshake            payload
// s_       in   s_valid / s_ready    s_sample_word[31:0]
// m_       out  m_valid / m_ready    m_value_bits[63:0], m_format_unsupported
// cfg      in   cfg_we               cfg_data[3:0] (format code)
//
// Input register, then decode into the result register.
// One item per cycle sustained while m_ready is high; each stage advances when the one after is free.
// A stall on m_ready holds both stages and drops s_ready only when both are full.
// Reset (aresetn low, synchronous) clears the valid bits; format code reads 1.
`include "seismic_sample_to_double_macros.svh"
module seismic_sample_to_double (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  ssd_pkg::fmt_code_t  cfg_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  ssd_pkg::sample_t    s_sample_word,
    output logic                m_valid,
    input  logic                m_ready,
    output ssd_pkg::dbl_t       m_value_bits,
    output logic                m_format_unsupported
);
    import ssd_pkg::*;

    fmt_code_t fmt_reg;
    sample_t   in_reg;
    logic      in_vld_reg;
    dbl_t      out_reg, out_next;
    logic      uns_reg, uns_next;
    logic      out_vld_reg;
    logic      out_adv, in_adv;

    // decode helpers
    logic        neg;
    logic [31:0] mag;
    logic [4:0]  p;
    logic [10:0] bexp;
    logic [51:0] frac;
    logic [63:0] shl;
    logic [31:0] m;
    logic [7:0]  sx;

    assign out_adv = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || out_adv;
    assign in_adv  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg     <= FMT_IBM;
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                fmt_reg <= cfg_data;
            end
            if (s_ready) begin
                in_vld_reg <= s_valid;
            end
            if (!out_vld_reg || m_ready) begin
                out_vld_reg <= in_vld_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_adv) begin
            in_reg <= s_sample_word;
        end
        if (out_adv) begin
            out_reg <= out_next;
            uns_reg <= uns_next;
        end
    end

    // Select magnitude and scale, normalize on the top set bit, then pack.
    always_comb begin
        neg      = 1'b0;
        mag      = 32'd0;
        sx       = 8'd0;
        uns_next = 1'b0;
        out_next = 64'd0;
        m        = 32'd0;
        case (fmt_reg)
            FMT_INT32: begin
                neg = in_reg[31];
                mag = neg ? (32'd0 - in_reg) : in_reg;
            end
            FMT_INT16: begin
                neg = in_reg[31];
                mag = neg ? (32'd0 - {16'hFFFF, in_reg[31:16]}) : {16'd0, in_reg[31:16]};
            end
            FMT_INT8: begin
                neg = in_reg[31];
                mag = neg ? (32'd0 - {24'hFFFFFF, in_reg[31:24]}) : {24'd0, in_reg[31:24]};
            end
            FMT_IEEE32: begin
                neg = in_reg[31];
                mag = {9'd0, in_reg[22:0]};
            end
            FMT_NONE, FMT_GAIN: begin
                neg = 1'b1;
            end
            default: begin
                neg = in_reg[31];
                mag = {8'd0, in_reg[23:0]};
                sx  = {1'b0, in_reg[30:24]};
            end
        endcase
        p    = top_bit(mag);
        shl  = {32'd0, mag} << (6'd52 - {1'b0, p});
        frac = shl[51:0];
        bexp = 11'd1023 + {6'd0, p};
        case (fmt_reg)
            FMT_NONE: begin
                out_next = DBL_MINUS_ONE;
            end
            FMT_GAIN: begin
                out_next = DBL_MINUS_ONE;
                uns_next = 1'b1;
            end
            FMT_INT32, FMT_INT16, FMT_INT8: begin
                out_next = (mag == 32'd0) ? 64'd0 : {neg, bexp, frac};
            end
            FMT_IEEE32: begin
                m = {9'd0, in_reg[22:0]};
                if (in_reg[30:23] == 8'hFF) begin
                    // NaN payload lands at the top of the fraction, quiet bit forced
                    out_next = {neg, 11'h7FF, (m != 32'd0), in_reg[21:0], 29'd0};
                end else if (in_reg[30:23] == 8'h00) begin
                    // subnormal: value m * 2^-149
                    out_next = (m == 32'd0) ? {neg, 63'd0}
                             : {neg, 11'(11'd874 + {6'd0, p}), frac};
                end else begin
                    out_next = {neg, 11'({3'd0, in_reg[30:23]} + 11'd896),
                                in_reg[22:0], 29'd0};
                end
            end
            default: begin
                // IBM: exp = p + 4*(e-64) - 24 + 1023 = p + 4e + 743
                out_next = (mag == 32'd0) ? {neg, 63'd0}
                         : {neg, 11'({6'd0, p} + {1'b0, sx, 2'b00} + 11'd743), frac};
            end
        endcase
    end

    assign m_valid              = out_vld_reg;
    assign m_value_bits         = out_reg;
    assign m_format_unsupported = uns_reg;

    `SSD_ASSERT(a_hold_stall, aclk, aresetn,
        (m_valid && !m_ready) |=> (m_valid && $stable(m_value_bits)),
        "result changed while stalled")
    `SSD_ASSERT(a_ready_free, aclk, aresetn,
        (!in_vld_reg) |-> s_ready, "input stage empty but not ready")
    `SSD_ASSERT(a_unsup, aclk, aresetn,
        (m_valid && m_format_unsupported) |-> (m_value_bits == DBL_MINUS_ONE),
        "unsupported flag without -1.0")
    `SSD_ASSERT_ALWAYS(a_reset, aclk,
        (!aresetn) |=> (!m_valid), "valid after reset")

endmodule

// ===== bench/seismic_sample_to_double_test.sv =====
// ----------------------------------------------------------------------------
// seismic_sample_to_double_test
// Streams sample words through the converter under every format code and
// checks each decoded double, and the unsupported flag, against a predictor.
// ----------------------------------------------------------------------------
module seismic_sample_to_double_test;
    import ssd_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 1060;

    // Decoded value of one sample, as the block should return it.
    typedef struct packed {
        dbl_t value;
        logic unsup;
    } decoded_t;

    // Exact double for sign * mag * 2^scale, mag nonzero and below 2^53.
    function automatic dbl_t pack_double(logic sgn, logic [52:0] mag, int scale);
        int   msb;
        dbl_t frac;
        logic [10:0] bexp;
        msb = 0;
        for (int i = 0; i < 53; i++) begin
            if (mag[i]) begin
                msb = i;
            end
        end
        bexp = 11'(msb + scale + 1023);
        frac = (64'(mag) << (52 - msb)) & 64'h000F_FFFF_FFFF_FFFF;
        return {sgn, bexp, frac[51:0]};
    endfunction

    function automatic dbl_t int_to_double(longint v);
        if (v == 0) begin
            return 64'd0;
        end
        if (v < 0) begin
            return pack_double(1'b1, 53'(-v), 0);
        end
        return pack_double(1'b0, 53'(v), 0);
    endfunction

    function automatic dbl_t ibm_to_double(sample_t w);
        if (w[23:0] == 24'd0) begin
            return {w[31], 63'd0};
        end
        return pack_double(w[31], 53'(w[23:0]), 4 * (int'(w[30:24]) - 64) - 24);
    endfunction

    function automatic dbl_t single_to_double(sample_t w);
        dbl_t r;
        if (w[30:23] == 8'hFF) begin
            r = {w[31], 11'h7FF, 52'd0};
            if (w[22:0] != 23'd0) begin
                r = r | (64'd1 << 51) | (64'(w[22:0]) << 29);
            end
            return r;
        end
        if (w[30:23] == 8'd0) begin
            if (w[22:0] == 23'd0) begin
                return {w[31], 63'd0};
            end
            return pack_double(w[31], 53'(w[22:0]), -149);
        end
        return {w[31], 11'(int'(w[30:23]) + 896), w[22:0], 29'd0};
    endfunction

    function automatic decoded_t decode_sample(fmt_code_t code, sample_t w);
        decoded_t d;
        d.unsup = 1'b0;
        case (code)
            FMT_NONE:   d.value = DBL_MINUS_ONE;
            FMT_INT32:  d.value = int_to_double(longint'($signed(w)));
            FMT_INT16:  d.value = int_to_double(longint'($signed(w[31:16])));
            FMT_GAIN: begin
                d.value = DBL_MINUS_ONE;
                d.unsup = 1'b1;
            end
            FMT_IEEE32: d.value = single_to_double(w);
            FMT_INT8:   d.value = int_to_double(longint'($signed(w[31:24])));
            default:    d.value = ibm_to_double(w);
        endcase
        return d;
    endfunction

    // Holds the decoded values still owed by the block, oldest first.
    class decode_scoreboard;
        decoded_t  pending[$];
        fmt_code_t code;
        int        mismatches;

        function void note_sample(sample_t w);
            pending.push_back(decode_sample(code, w));
        endfunction

        function void check_value(dbl_t value, logic unsup);
            decoded_t want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected item: value %h unsup %b", value, unsup);
                end
                return;
            end
            want = pending.pop_front();
            if (want.value !== value || want.unsup !== unsup) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch: expected %h/%b, got %h/%b",
                             want.value, want.unsup, value, unsup);
                end
            end
        endfunction
    endclass

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      cfg_we = 1'b0;
    fmt_code_t cfg_data = FMT_IBM;
    logic      s_valid = 1'b0;
    logic      s_ready;
    sample_t   s_sample_word = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    dbl_t      m_value_bits;
    logic      m_format_unsupported;

    decode_scoreboard sb;
    bit  sending_done = 0;
    bit  long_hold = 0;
    int  idle_cycles = 0;

    seismic_sample_to_double dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_we               (cfg_we),
        .cfg_data             (cfg_data),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_sample_word        (s_sample_word),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_value_bits         (m_value_bits),
        .m_format_unsupported (m_format_unsupported)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Note inputs and check results at the rising edge; count idle cycles.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                sb.note_sample(s_sample_word);
            end
            if (m_valid && m_ready) begin
                sb.check_value(m_value_bits, m_format_unsupported);
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Offer one item after a random gap and hold it until accepted; valid
    // stays high afterwards so a follower can go back to back.
    task automatic send_sample(sample_t w, bit no_gap);
        int gap;
        gap = (no_gap || $urandom_range(3) == 0) ? 0 : $urandom_range(16);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_sample_word <= w;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Drain everything owed, let the pipe settle, then write the format code.
    task automatic set_format(fmt_code_t code);
        s_valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_data <= code;
        @(negedge aclk);
        cfg_we <= 1'b0;
        sb.code = code;
    endtask

    // Random word biased toward the corners of each format.
    function automatic sample_t random_sample();
        case ($urandom_range(5))
            0: return {$urandom_range(1), 8'hFF, 23'($urandom)};
            1: return {$urandom_range(1), 8'h00, 23'($urandom)};
            2: return {8'($urandom), 24'd0};
            3: return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    // Receiver: random stalls, with one long hold-off to fill the pipe.
    initial begin
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (long_hold) begin
                m_ready <= 1'b0;
                repeat (60) @(negedge aclk);
                long_hold = 0;
            end
            if ($urandom_range(3) == 0) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b0;
                repeat ($urandom_range(16)) @(negedge aclk);
                m_ready <= 1'b1;
                @(negedge aclk);
            end
        end
    end

    initial begin
        fmt_code_t codes[] = '{FMT_NONE, FMT_IBM, FMT_INT32, FMT_INT16, FMT_GAIN,
                               FMT_IEEE32, FMT_INT8, 4'd6, 4'd7, 4'd15};
        sample_t directed[] = '{32'h0000_0000, 32'h8000_0000, 32'hFFFF_FFFF,
                                32'h7FFF_FFFF, 32'h7F80_0000, 32'hFF80_0000,
                                32'h7FC0_0001, 32'hFFBF_FFFF, 32'h0000_0001,
                                32'h807F_FFFF, 32'h4110_0000, 32'hC1FF_FFFF,
                                32'h00FF_FFFF, 32'h7F00_0000, 32'h0001_FFFF,
                                32'h8000_00FF, 32'h0100_0000};
        sb = new();
        sb.code = FMT_IBM;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        // Run the directed words under the reset code first.
        foreach (directed[i]) send_sample(directed[i], 1'b0);
        foreach (codes[c]) begin
            set_format(codes[c]);
            foreach (directed[i]) send_sample(directed[i], 1'b0);
        end
        // Random phases: a fresh code every stretch, one long receiver hold.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 125 == 0) begin
                set_format(n == 0 ? FMT_IEEE32 : 4'($urandom));
            end
            if (n == 300) begin
                long_hold = 1;
            end
            send_sample(random_sample(), (n >= 300 && n < 340));
        end
        s_valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);
        if (sb.mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+sv
sv/ssd_pkg.sv
sv/seismic_sample_to_double.sv
bench/seismic_sample_to_double_test.sv
